FILE: sv/bgns_pkg.sv
// Shared types and constants of the binary grid neighbourhood smoother.
// No dependencies; the top level, bgns_seq, bgns_window and the testbench refer to it by scoped names.
`default_nettype none

package bgns_pkg;

	localparam int ROW_W    = 16;
	localparam int RLEN_W   = 11;
	localparam int THR_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_FIRST_ROW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_LAST_ROW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_FIRST_COL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_LAST_COL    = 3'd6;

	typedef struct packed {
		logic [ROW_W-1:0]  row_count;
		logic [RLEN_W-1:0] row_length;
		logic [THR_W-1:0]  threshold;
		logic              fill_before_first_row;
		logic              fill_after_last_row;
		logic              fill_before_first_column;
		logic              fill_after_last_column;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		row_count:                16'd1,
		row_length:               11'd1,
		threshold:                4'd4,
		fill_before_first_row:    1'b0,
		fill_after_last_row:      1'b0,
		fill_before_first_column: 1'b0,
		fill_after_last_column:   1'b0
	};

	// Where the output cell sits, as seen by the window stage
	typedef struct packed {
		logic emit;   // this item produces a result
		logic last;   // result is the final cell of the frame
		logic top;    // row above the output cell is outside the grid
		logic bot;    // row below the output cell is outside the grid
		logic left;   // column left of the output cell is outside
		logic right;  // column right of the output cell is outside
	} pos_t;

endpackage

`default_nettype wire

FILE: sv/bgns_cell_if.sv
// Input channel of the smoother: one grid cell or flush marker per transfer.
// No dependencies.
`default_nettype none

interface bgns_cell_if;
	logic valid;
	logic ready;
	logic cell_value;
	logic flush;

	modport source (output valid, output cell_value, output flush, input ready);
	modport sink   (input valid, input cell_value, input flush, output ready);
endinterface

`default_nettype wire

FILE: sv/bgns_result_if.sv
// Output channel of the smoother: one smoothed cell per transfer.
// No dependencies.
`default_nettype none

interface bgns_result_if;
	logic valid;
	logic ready;
	logic smoothed_value;
	logic last_of_frame;

	modport source (output valid, output smoothed_value, output last_of_frame, input ready);
	modport sink   (input valid, input smoothed_value, input last_of_frame, output ready);
endinterface

`default_nettype wire

FILE: sv/binary_grid_neighbourhood_smoother.sv
// Top level of the binary grid neighbourhood smoother: configuration registers
// and the sequencer, line buffer and window stages. Depends on bgns_pkg,
// bgns_cell_if, bgns_result_if, bgns_seq, bgns_linebuf and bgns_window.
`default_nettype none

// One smoothing pass of 3x3 cave smoothing over a binary grid streamed in
// raster order, one cell per transfer on grid. Each cell's result is the sum
// of its 3x3 window (itself included) against threshold: above gives 1, below
// gives 0, equal keeps the cell. Positions outside the grid count as the four
// fill flags, the row-side flag winning at corners. Results come out one row
// plus one cell behind the input, so after the last cell send row_length+1
// transfers with flush set to drain the frame; last_of_frame marks the final
// result and the next transfer starts a new frame. Throughput is one cell per
// clock while no waiting result holds the window stage: the two previous rows
// live in one MAX_ROW_LENGTH x 2-bit RAM that is read at the cell's column when
// the cell is taken and written back as the cell leaves the window stage, which
// a waiting result can delay, with the write forwarded when the next cell reads
// the same column (row length one, frame restart). The RAM's single read and
// single write per cycle set that rate. An accepted cell passes from the window
// stage register into the result register, staying in the window stage while
// a waiting result holds it. Columns never written since reset read as empty
// through a fill mark, so there is no clearing pass and the block takes cells
// right after reset. Write configuration only while no results are outstanding.
module binary_grid_neighbourhood_smoother #(
	parameter int MAX_ROW_LENGTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bgns_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bgns_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	bgns_cell_if.sink                                grid,
	bgns_result_if.source                            smoothed
);

	localparam int CW = $clog2(MAX_ROW_LENGTH);

	bgns_pkg::cfg_t cfg_q;
	bgns_pkg::pos_t pos;
	logic [CW-1:0]  col;
	logic [2:0]     trio;
	logic           accept, commit, adv, in_bit;

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= bgns_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bgns_pkg::CFG_ROW_COUNT: cfg_q.row_count <= cfg_wdata;
				bgns_pkg::CFG_ROW_LENGTH: cfg_q.row_length <= cfg_wdata[bgns_pkg::RLEN_W-1:0];
				bgns_pkg::CFG_THRESHOLD: cfg_q.threshold <= cfg_wdata[bgns_pkg::THR_W-1:0];
				bgns_pkg::CFG_FILL_FIRST_ROW: cfg_q.fill_before_first_row <= cfg_wdata[0];
				bgns_pkg::CFG_FILL_LAST_ROW: cfg_q.fill_after_last_row <= cfg_wdata[0];
				bgns_pkg::CFG_FILL_FIRST_COL: cfg_q.fill_before_first_column <= cfg_wdata[0];
				bgns_pkg::CFG_FILL_LAST_COL: cfg_q.fill_after_last_column <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Take a new cell whenever the window stage can move on, even while a
	// finished result still waits in the output register.
	assign grid.ready = adv;
	assign accept     = grid.valid && grid.ready;
	// a flush transfer acts as an empty cell
	assign in_bit     = grid.flush ? 1'b0 : grid.cell_value;

	bgns_seq #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (accept),
		.col     (col),
		.pos     (pos)
	);

	bgns_linebuf #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH)
	) u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col),
		.in_bit  (in_bit),
		.commit  (commit),
		.trio    (trio)
	);

	bgns_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.pos    (pos),
		.trio   (trio),
		.commit (commit),
		.adv    (adv),
		.res    (smoothed)
	);

endmodule

`default_nettype wire

FILE: sv/bgns_seq.sv
// Position sequencer: input and output raster counters, frame end, border flags.
// Depends on bgns_pkg.
`default_nettype none

module bgns_seq #(
	parameter int MAX_ROW_LENGTH = 1024,
	localparam int LW = $clog2(MAX_ROW_LENGTH + 1),
	localparam int CW = $clog2(MAX_ROW_LENGTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bgns_pkg::cfg_t    cfg,
	input  wire logic              advance,
	output logic [CW-1:0]          col,
	output bgns_pkg::pos_t         pos
);

	localparam logic [31:0] MAX32 = 32'(MAX_ROW_LENGTH);

	logic [bgns_pkg::ROW_W-1:0] in_row_q, out_row_q;
	logic [LW-1:0]              in_col_q, out_col_q;

	logic [bgns_pkg::ROW_W-1:0] rows, rows_m1;
	logic [LW-1:0]              len, len_m1;
	logic [31:0]                rl32;

	logic [bgns_pkg::ROW_W-1:0] ir0, or0, ir1, or1;
	logic [LW-1:0]              ic0, oc0, ic1, oc1;
	logic                       emit, last;

	always_comb begin
		rows = (cfg.row_count == '0) ? bgns_pkg::ROW_W'(1) : cfg.row_count;
		rows_m1 = rows - bgns_pkg::ROW_W'(1);
		rl32 = 32'(cfg.row_length);
		if (rl32 == 32'd0) begin
			len = LW'(1);
		end else if (rl32 > MAX32) begin
			len = LW'(MAX_ROW_LENGTH);
		end else begin
			len = LW'(rl32);
		end
		len_m1 = len - LW'(1);
	end

	always_comb begin
		ic0 = in_col_q;
		ir0 = in_row_q;
		oc0 = out_col_q;
		or0 = out_row_q;
		// wrap counters left beyond a row length that shrank
		if (ic0 >= len) begin
			ic0 = '0;
			ir0 = ir0 + bgns_pkg::ROW_W'(1);
		end
		if (oc0 >= len) begin
			oc0 = '0;
			or0 = or0 + bgns_pkg::ROW_W'(1);
		end
		if (or0 >= rows) begin
			ic0 = '0;
			ir0 = '0;
			oc0 = '0;
			or0 = '0;
		end

		emit = (ir0 >= bgns_pkg::ROW_W'(2)) || (ir0 == bgns_pkg::ROW_W'(1) && ic0 != '0);
		last = emit && (or0 == rows_m1) && (oc0 == len_m1);

		ic1 = ic0 + LW'(1);
		ir1 = ir0;
		if (ic1 >= len) begin
			ic1 = '0;
			ir1 = ir0 + bgns_pkg::ROW_W'(1);
		end
		oc1 = oc0;
		or1 = or0;
		if (emit) begin
			oc1 = oc0 + LW'(1);
			if (oc1 >= len) begin
				oc1 = '0;
				or1 = or0 + bgns_pkg::ROW_W'(1);
			end
		end
		if (last) begin
			ic1 = '0;
			ir1 = '0;
			oc1 = '0;
			or1 = '0;
		end
	end

	assign col       = ic0[CW-1:0];
	assign pos.emit  = emit;
	assign pos.last  = last;
	assign pos.top   = (or0 == '0);
	assign pos.bot   = (or0 == rows_m1);
	assign pos.left  = (oc0 == '0);
	assign pos.right = (oc0 == len_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (advance) begin
			in_row_q  <= ir1;
			in_col_q  <= ic1;
			out_row_q <= or1;
			out_col_q <= oc1;
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pos.last |=> in_row_q == '0 && in_col_q == '0 &&
			out_row_q == '0 && out_col_q == '0)
		else $error("counters not cleared after the final cell");

endmodule

`default_nettype wire

FILE: sv/bgns_linebuf.sv
// Two-row line buffer in one synchronous RAM with read-modify-write,
// same-column forwarding and a fill mark for never-written columns. Depends on nothing.
`default_nettype none

module bgns_linebuf #(
	parameter int MAX_ROW_LENGTH = 1024,
	localparam int LW = $clog2(MAX_ROW_LENGTH + 1),
	localparam int CW = $clog2(MAX_ROW_LENGTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [CW-1:0] rd_addr,
	input  wire logic          in_bit,
	input  wire logic          commit,
	output logic [2:0]         trio
);

	// bit 0: two rows up, bit 1: one row up
	logic [1:0]    mem [MAX_ROW_LENGTH];
	logic [1:0]    mem_q;
	logic [CW-1:0] col_s1;
	logic          bit_s1;
	logic [1:0]    fwd_val_s1;
	logic          fwd_s1, blank_s1;
	logic [LW-1:0] fill_q;

	logic [1:0] lb_s1, wr_data;
	logic       fwd, blank;

	assign lb_s1   = fwd_s1 ? fwd_val_s1 : (blank_s1 ? 2'b00 : mem_q);
	assign wr_data = {bit_s1, lb_s1[1]};
	assign trio    = {bit_s1, lb_s1};

	// the entry being written back this cycle is the one read
	assign fwd   = commit && (rd_addr == col_s1);
	assign blank = LW'(rd_addr) >= fill_q;

	always_ff @(posedge clk) begin
		if (commit) begin
			mem[col_s1] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			col_s1     <= rd_addr;
			bit_s1     <= in_bit;
			fwd_val_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1   <= 1'b0;
			blank_s1 <= 1'b1;
			fill_q   <= '0;
		end else begin
			if (rd_en) begin
				fwd_s1   <= fwd;
				blank_s1 <= blank;
			end
			// columns are first written in ascending order, so the mark advances by one
			if (commit && LW'(col_s1) == fill_q) begin
				fill_q <= fill_q + LW'(1);
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(MAX_ROW_LENGTH))
		else $error("fill mark beyond buffer depth");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + LW'(1)))
		else $error("fill mark skipped a column");

endmodule

`default_nettype wire

FILE: sv/bgns_window.sv
// 3x3 window register, neighbour count with border fill, threshold decision
// and output register. Depends on bgns_pkg and bgns_result_if.
`default_nettype none

module bgns_window (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bgns_pkg::cfg_t cfg,
	input  wire logic           accept,
	input  wire bgns_pkg::pos_t pos,
	input  wire logic [2:0]     trio,
	output logic                commit,
	output logic                adv,
	bgns_result_if.source       res
);

	logic           s1_valid_q;
	bgns_pkg::pos_t pos_s1;
	logic [8:0]     window_q;
	logic           out_valid_q, out_value_q, out_last_q;

	logic [8:0] win_next;
	logic [3:0] count;
	logic       b, value;

	assign adv    = !s1_valid_q || !pos_s1.emit || !out_valid_q || res.ready;
	assign commit = s1_valid_q && adv;

	assign win_next = {trio, window_q[8:3]};

	// row-side fill wins at the corners
	always_comb begin
		count = '0;
		b = 1'b0;
		for (int dc = 0; dc < 3; dc++) begin
			for (int dr = 0; dr < 3; dr++) begin
				if (dr == 0 && pos_s1.top) begin
					b = cfg.fill_before_first_row;
				end else if (dr == 2 && pos_s1.bot) begin
					b = cfg.fill_after_last_row;
				end else if (dc == 0 && pos_s1.left) begin
					b = cfg.fill_before_first_column;
				end else if (dc == 2 && pos_s1.right) begin
					b = cfg.fill_after_last_column;
				end else begin
					b = win_next[4'(dc * 3 + dr)];
				end
				count = count + 4'(b);
			end
		end
		if (count > cfg.threshold) begin
			value = 1'b1;
		end else if (count < cfg.threshold) begin
			value = 1'b0;
		end else begin
			value = win_next[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			pos_s1      <= '0;
			window_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				pos_s1     <= pos;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			if (commit) begin
				window_q <= win_next;
			end
			if (commit && pos_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && pos_s1.emit) begin
			out_value_q <= value;
			out_last_q  <= pos_s1.last;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.smoothed_value = out_value_q;
	assign res.last_of_frame  = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit && pos_s1.emit |-> !out_valid_q || res.ready)
		else $error("result register overwritten before transfer");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !commit |=> s1_valid_q && $stable(pos_s1) && $stable(window_q))
		else $error("stalled window stage lost its item");

endmodule

`default_nettype wire

FILE: test/bgns_smoothing_checker.sv
// Result checker of the binary grid neighbourhood smoother testbench.
// Depends on bgns_pkg, bgns_cell_if and bgns_result_if.
`timescale 1ns / 1ps

module bgns_smoothing_checker #(
	parameter int MAX_ROW_LENGTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bgns_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bgns_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	bgns_cell_if                                grid,
	bgns_result_if                              smoothed,
	output int                                  fail_count,
	output int                                  pending
);

	typedef struct packed {
		logic smoothed_value;
		logic last_of_frame;
	} smoothed_cell_t;

	bgns_pkg::cfg_t regs = bgns_pkg::CFG_RESET;

	// two rows back and one row back at each column
	bit          older_row [MAX_ROW_LENGTH];
	bit          newer_row [MAX_ROW_LENGTH];
	logic [8:0]  window = '0;
	logic [15:0] in_row = '0;
	logic [15:0] out_row = '0;
	int unsigned in_col = 0;
	int unsigned out_col = 0;

	smoothed_cell_t smoothed_due [$];
	smoothed_cell_t due;

	task automatic clear_position();
		in_row = '0;
		in_col = 0;
		out_row = '0;
		out_col = 0;
	endtask

	task automatic note_failure(input smoothed_cell_t want, input bit have_want);
		if (fail_count < 10) begin
			if (have_want)
				$display("%0t: smoothed cell mismatch: expected value %0b last %0b, got value %0b last %0b",
					$realtime, want.smoothed_value, want.last_of_frame,
					smoothed.smoothed_value, smoothed.last_of_frame);
			else
				$display("%0t: smoothed cell with nothing due: got value %0b last %0b",
					$realtime, smoothed.smoothed_value, smoothed.last_of_frame);
		end
		fail_count++;
	endtask

	// Take one cell into the line buffers and the window, queue the cell it completes.
	task automatic smooth_cell(input logic cell_in, input logic drain);
		int unsigned rows, len, count;
		int r, c, dr, dc;
		logic sample, center, value, last;
		logic [2:0] trio;
		smoothed_cell_t res;

		rows = (regs.row_count == 0) ? 1 : regs.row_count;
		len = (regs.row_length == 0) ? 1 : regs.row_length;
		if (len > MAX_ROW_LENGTH)
			len = MAX_ROW_LENGTH;
		sample = drain ? 1'b0 : cell_in;

		if (in_col >= len) begin
			in_col = 0;
			in_row++;
		end
		if (out_col >= len) begin
			out_col = 0;
			out_row++;
		end
		if (out_row >= rows)
			clear_position();

		trio = {sample, newer_row[in_col], older_row[in_col]};
		older_row[in_col] = newer_row[in_col];
		newer_row[in_col] = sample;
		window = {trio, window[8:3]};

		if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
			count = 0;
			for (dc = 0; dc < 3; dc++) begin
				for (dr = 0; dr < 3; dr++) begin
					r = int'(out_row) - 1 + dr;
					c = int'(out_col) - 1 + dc;
					if (r < 0)
						count += regs.fill_before_first_row;
					else if (r >= int'(rows))
						count += regs.fill_after_last_row;
					else if (c < 0)
						count += regs.fill_before_first_column;
					else if (c >= int'(len))
						count += regs.fill_after_last_column;
					else
						count += window[dc*3+dr];
				end
			end
			center = window[4];
			if (count > regs.threshold)
				value = 1'b1;
			else if (count < regs.threshold)
				value = 1'b0;
			else
				value = center;
			last = (out_row == rows - 1) && (out_col == len - 1);
			res.smoothed_value = value;
			res.last_of_frame = last;
			smoothed_due = {smoothed_due, res};
			if (last) begin
				clear_position();
				return;
			end
			out_col++;
			if (out_col >= len) begin
				out_col = 0;
				out_row++;
			end
		end

		in_col++;
		if (in_col >= len) begin
			in_col = 0;
			in_row++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = bgns_pkg::CFG_RESET;
			for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
				older_row[i] = 1'b0;
				newer_row[i] = 1'b0;
			end
			window = '0;
			clear_position();
			smoothed_due.delete();
			fail_count = 0;
		end else begin
			if (smoothed.valid && smoothed.ready) begin
				if (smoothed_due.size() == 0) begin
					note_failure(due, 1'b0);
				end else begin
					due = smoothed_due.pop_front();
					if (smoothed.smoothed_value !== due.smoothed_value ||
						smoothed.last_of_frame !== due.last_of_frame)
						note_failure(due, 1'b1);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					bgns_pkg::CFG_ROW_COUNT:      regs.row_count = cfg_wdata;
					bgns_pkg::CFG_ROW_LENGTH:     regs.row_length = cfg_wdata[bgns_pkg::RLEN_W-1:0];
					bgns_pkg::CFG_THRESHOLD:      regs.threshold = cfg_wdata[bgns_pkg::THR_W-1:0];
					bgns_pkg::CFG_FILL_FIRST_ROW: regs.fill_before_first_row = cfg_wdata[0];
					bgns_pkg::CFG_FILL_LAST_ROW:  regs.fill_after_last_row = cfg_wdata[0];
					bgns_pkg::CFG_FILL_FIRST_COL: regs.fill_before_first_column = cfg_wdata[0];
					bgns_pkg::CFG_FILL_LAST_COL:  regs.fill_after_last_column = cfg_wdata[0];
					default: ;
				endcase
			end
			if (grid.valid && grid.ready)
				smooth_cell(grid.cell_value, grid.flush);
		end
		pending = smoothed_due.size();
	end

endmodule

FILE: test/binary_grid_neighbourhood_smoother_test.sv
// Testbench top of the binary grid neighbourhood smoother: clock, reset, cell
// stimulus, result back-pressure and the verdict. Depends on bgns_pkg, both
// channel interfaces, the smoother and bgns_smoothing_checker.
`timescale 1ns / 1ps

module binary_grid_neighbourhood_smoother_test;

	localparam int MAX_ROW_LENGTH = 1024;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 8;      // a cell without a result leaves the window stage with no stall
	localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
	localparam int PHASE_ITEMS    = 80;     // at least this many random items per idling phase
	localparam int LIMIT_CYCLES   = 400000;

	// register index that decodes to nothing
	localparam logic [bgns_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef enum int {DRAIN_FLUSH, DRAIN_CELLS, DRAIN_SHORT} drain_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [bgns_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bgns_pkg::CFG_DATA_W-1:0] cfg_wdata;

	bgns_cell_if   grid_ch ();
	bgns_result_if result_ch ();

	int fail_count;
	int pending;
	int unsigned cells_sent = 0;
	int unsigned cycle_count = 0;
	int sender_gap_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;

	always #5 clk = ~clk;

	binary_grid_neighbourhood_smoother #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.grid      (grid_ch),
		.smoothed  (result_ch)
	);

	bgns_smoothing_checker #(
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.grid       (grid_ch),
		.smoothed   (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Give up on a hung run.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Result side: stall at the phase's rate, or hold off for a long stretch on
	// request so that the block fills up and pushes back on the cell stream.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one cell, after a random gap, and hold it until the transfer.
	// Valid stays high on return so that back-to-back cells need no second
	// assignment in the same step; lower it only before a gap or a pause.
	task automatic send_item(input logic cell_in, input logic drain);
		int gap;
		gap = 0;
		while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct)
			gap++;
		if (gap > 0) begin
			grid_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		grid_ch.valid      <= 1'b1;
		grid_ch.cell_value <= cell_in;
		grid_ch.flush      <= drain;
		do @(posedge clk); while (!grid_ch.ready);
		cells_sent++;
	endtask

	// Drop valid, wait for every due result, then let the pipe settle.
	task automatic wait_idle();
		grid_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bgns_pkg::CFG_IDX_W-1:0] idx,
		input logic [bgns_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Program every register once the block is idle. Unused upper bits of the
	// narrow registers carry noise; fills is {first row, last row, first col, last col}.
	task automatic set_grid(input logic [15:0] rows, input logic [10:0] len,
		input logic [3:0] thr, input logic [3:0] fills);
		wait_idle();
		write_reg(bgns_pkg::CFG_ROW_COUNT, rows);
		write_reg(bgns_pkg::CFG_ROW_LENGTH, {5'($urandom), len});
		write_reg(bgns_pkg::CFG_THRESHOLD, {12'($urandom), thr});
		write_reg(bgns_pkg::CFG_FILL_FIRST_ROW, {15'($urandom), fills[3]});
		write_reg(bgns_pkg::CFG_FILL_LAST_ROW, {15'($urandom), fills[2]});
		write_reg(bgns_pkg::CFG_FILL_FIRST_COL, {15'($urandom), fills[1]});
		write_reg(bgns_pkg::CFG_FILL_LAST_COL, {15'($urandom), fills[0]});
		if ($urandom_range(3) == 0)
			write_reg(CFG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// One frame of random cells followed by its drain. A cell drain mixes plain
	// cells in place of flush items; a short drain leaves the frame open so the
	// next frame's cells finish it.
	task automatic send_frame(input int rows, input int len, input drain_t drain_kind);
		int density, drain_n;
		density = $urandom_range(15, 85);
		drain_n = len + 1;
		if (drain_kind == DRAIN_SHORT)
			drain_n -= $urandom_range(1, len);
		repeat (rows * len) send_item($urandom_range(99) < density, 1'b0);
		repeat (drain_n) begin
			if (drain_kind == DRAIN_CELLS)
				send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
			else
				send_item(1'($urandom_range(1)), 1'b1);
		end
	endtask

	initial begin
		int unsigned phase_start;
		int rows_eff, len_eff, pick;
		logic [15:0] rows_w;
		logic [10:0] len_w;
		logic [3:0] thr_w;

		grid_ch.valid      <= 1'b0;
		grid_ch.cell_value <= 1'b0;
		grid_ch.flush      <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_wdata          <= '0;
		arst_n             <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, a 1x1 grid: one cell, then two flush items whose
		// cell value must be ignored.
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b1);

		// Zero sizes act as one; a plain cell stands in for a flush item.
		set_grid(16'd0, 11'd0, 4'd0, 4'b1111);
		send_item(1'b0, 1'b0);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b1);

		// All fills set, all ones: every window sums to nine, equal to the
		// threshold, so each cell keeps its value.
		set_grid(16'd2, 11'd3, 4'd9, 4'b1111);
		repeat (6) send_item(1'b1, 1'b0);
		repeat (4) send_item(1'b1, 1'b1);

		// Threshold above nine with the largest row count, then shrink the row
		// count in the middle of the frame so the open frame ends early.
		set_grid(16'hFFFF, 11'd2, 4'd15, 4'b0101);
		repeat (6) send_item(1'($urandom_range(1)), 1'b0);
		set_grid(16'd2, 11'd2, 4'd15, 4'b1010);
		repeat (3) send_item(1'($urandom_range(1)), 1'b0);
		repeat (3) send_item(1'b0, 1'b1);

		// Random frames over the idling phases: none, sender idle, receiver
		// stalling, both. The first phase also holds the receiver off for a
		// long stretch while cells keep coming.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin
					sender_gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_gap_pct = 68;
					stall_pct = 0;
				end
				2: begin
					sender_gap_pct = 0;
					stall_pct = 68;
				end
				default: begin
					sender_gap_pct = 17;
					stall_pct = 17;
				end
			endcase

			rows_w = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
			pick = $urandom_range(9);
			if (pick == 0)
				len_w = 11'd0;
			else if (pick == 1)
				len_w = 11'($urandom_range(9, 40));
			else
				len_w = 11'($urandom_range(1, 8));
			thr_w = ($urandom_range(9) < 7) ? 4'($urandom_range(3, 6))
			                                 : 4'($urandom_range(0, 15));
			set_grid(rows_w, len_w, thr_w, 4'($urandom));
			rows_eff = (rows_w == 0) ? 1 : rows_w;
			len_eff = (len_w == 0) ? 1 : len_w;

			if (phase == 0)
				hold_req = 1'b1;

			phase_start = cells_sent;
			while (cells_sent - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					send_frame(rows_eff, len_eff, DRAIN_FLUSH);
				end else if (pick < 85) begin
					send_frame(rows_eff, len_eff, DRAIN_CELLS);
				end else if (pick < 93) begin
					send_frame(rows_eff, len_eff, DRAIN_SHORT);
				end else begin
					// stray items ahead of the frame
					repeat ($urandom_range(1, 6))
						send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
					send_frame(rows_eff, len_eff, DRAIN_FLUSH);
				end
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
sv/bgns_pkg.sv
sv/bgns_cell_if.sv
sv/bgns_result_if.sv
sv/bgns_seq.sv
sv/bgns_linebuf.sv
sv/bgns_window.sv
sv/binary_grid_neighbourhood_smoother.sv
test/bgns_smoothing_checker.sv
test/binary_grid_neighbourhood_smoother_test.sv
